/* sv/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the rising clock, idle while reset is asserted
`define ASSERT_CLKRST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/sit_pkg.sv */
// package: widths, codes and word types of the swap interleave translator
package sit_pkg;

    localparam int BLK_IN_W        = 24;
    localparam int BYTES_W         = 16;
    localparam int BLK_W           = BLK_IN_W + 1;
    localparam int SWAP_W          = 24;
    localparam int IL_W            = 16;
    localparam int CNT_W           = 3;
    localparam int DEV_W           = 16;
    localparam int IDX_W           = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    localparam int BLOCK_BYTES     = 512;
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);
    localparam int SZ_W            = BYTES_W + 1 - BLOCK_SHIFT;
    localparam int MINIROOT_BLOCKS = 4096;
    localparam int MAX_DEVICES     = 4;

    localparam logic [SWAP_W-1:0] SWAP_SIZE_RST  = '0;
    localparam logic [IL_W-1:0]   IL_SIZE_RST    = IL_W'(1024);
    localparam logic [CNT_W-1:0]  DEV_COUNT_RST  = CNT_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SWAP_SIZE  = 3'd0,
        REG_IL_SIZE    = 3'd1,
        REG_DEV_COUNT  = 3'd2,
        REG_MINIROOT   = 3'd3,
        REG_DEVICE_0   = 3'd4,
        REG_DEVICE_1   = 3'd5,
        REG_DEVICE_2   = 3'd6,
        REG_DEVICE_3   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_CROSS  = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef struct packed {
        logic [SWAP_W-1:0]                  swap_size;
        logic [IL_W-1:0]                    interleave_size;
        logic [CNT_W-1:0]                   device_count;
        logic                               miniroot_enable;
        logic [MAX_DEVICES-1:0][DEV_W-1:0]  device;
    } cfg_t;

    typedef struct packed {
        logic [BLK_IN_W-1:0] block_number;
        logic [BYTES_W-1:0]  byte_count;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [IDX_W-1:0]    device_index;
        logic [DEV_W-1:0]    device_number;
        logic [BLK_IN_W-1:0] device_block;
    } rsp_t;

    // sideband riding along the chunk divider
    typedef struct packed {
        logic             fail_range;
        logic             multi;
        logic [SZ_W-1:0]  sz;
        logic [BLK_W-1:0] blk;
    } side1_t;

    // sideband riding along the device-count divider
    typedef struct packed {
        side1_t           s;
        logic [IL_W-1:0]  off;
    } side2_t;

endpackage

/* sv/sit_div_cell.sv */
// one restoring division cell: one quotient bit per cycle while en is high, sideband carried along
module sit_div_cell #(
    parameter int NUM_W  = sit_pkg::BLK_W,
    parameter int DEN_W  = sit_pkg::IL_W,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [DEN_W-1:0]  den,
    input  logic              valid_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [DEN_W-1:0]  rem_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [NUM_W-1:0]  num_out,
    output logic [DEN_W-1:0]  rem_out,
    output logic [SIDE_W-1:0] side_out
);
    import sit_pkg::*;

    logic              valid_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  num_next;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  rem_next;
    logic [SIDE_W-1:0] side_reg;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial    = {rem_in, num_in[NUM_W-1]};
        diff     = trial - {1'b0, den};
        ge       = (trial >= {1'b0, den});
        rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num_next = {num_in[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign num_out   = num_reg;
    assign rem_out   = rem_reg;
    assign side_out  = side_reg;

endmodule

/* sv/sit_div_chain.sv */
// row of division cells, one per quotient bit
module sit_div_chain #(
    parameter int NUM_W  = sit_pkg::BLK_W,
    parameter int DEN_W  = sit_pkg::IL_W,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [DEN_W-1:0]  den,
    input  logic              valid_in,
    input  logic [NUM_W-1:0]  num_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              valid_out,
    output logic [NUM_W-1:0]  quot,
    output logic [DEN_W-1:0]  rem,
    output logic [SIDE_W-1:0] side_out
);
    import sit_pkg::*;

    logic              valid_w [NUM_W+1];
    logic [NUM_W-1:0]  num_w   [NUM_W+1];
    logic [DEN_W-1:0]  rem_w   [NUM_W+1];
    logic [SIDE_W-1:0] side_w  [NUM_W+1];

    assign valid_w[0] = valid_in;
    assign num_w[0]   = num_in;
    assign rem_w[0]   = '0;
    assign side_w[0]  = side_in;

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_cell
        sit_div_cell #(
            .NUM_W  (NUM_W),
            .DEN_W  (DEN_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .den       (den),
            .valid_in  (valid_w[i]),
            .num_in    (num_w[i]),
            .rem_in    (rem_w[i]),
            .side_in   (side_w[i]),
            .valid_out (valid_w[i+1]),
            .num_out   (num_w[i+1]),
            .rem_out   (rem_w[i+1]),
            .side_out  (side_w[i+1])
        );
    end

    assign valid_out = valid_w[NUM_W];
    assign quot      = num_w[NUM_W];
    assign rem       = rem_w[NUM_W];
    assign side_out  = side_w[NUM_W];

endmodule

/* sv/sit_front.sv */
// front stages: mini-root offset, block rounding, swap end check
module sit_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      load,
    input  sit_pkg::req_t             req,
    input  sit_pkg::cfg_t             cfg,
    input  logic                      multi,
    output logic                      valid_out,
    output logic [sit_pkg::BLK_W-1:0] blk_out,
    output sit_pkg::side1_t           side_out
);
    import sit_pkg::*;

    logic             a_valid_reg;
    logic [BLK_W-1:0] a_blk_reg;
    logic [BLK_W-1:0] a_blk_next;
    logic [SZ_W-1:0]  a_sz_reg;
    logic [SZ_W-1:0]  a_sz_next;
    logic [BYTES_W:0] bytes_round;
    logic             b_valid_reg;
    logic [BLK_W-1:0] b_blk_reg;
    side1_t           b_side_reg;
    side1_t           b_side_next;
    logic [BLK_W:0]   blk_end;

    always_comb
    begin
        bytes_round = {1'b0, req.byte_count} + (BYTES_W+1)'(BLOCK_BYTES - 1);
        a_sz_next   = bytes_round[BYTES_W:BLOCK_SHIFT];
        a_blk_next  = {1'b0, req.block_number}
                    + (cfg.miniroot_enable ? BLK_W'(MINIROOT_BLOCKS) : '0);
    end

    always_comb
    begin
        blk_end                = {1'b0, a_blk_reg} + (BLK_W+1)'(a_sz_reg);
        b_side_next.fail_range = (blk_end > (BLK_W+1)'(cfg.swap_size));
        b_side_next.multi      = multi;
        b_side_next.sz         = a_sz_reg;
        b_side_next.blk        = a_blk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= load;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_blk_reg  <= a_blk_next;
            a_sz_reg   <= a_sz_next;
            b_blk_reg  <= a_blk_reg;
            b_side_reg <= b_side_next;
        end
    end

    assign valid_out = b_valid_reg;
    assign blk_out   = b_blk_reg;
    assign side_out  = b_side_reg;

endmodule

/* sv/sit_back.sv */
// back stage: device block product, interleave crossing check, result word
module sit_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  sit_pkg::cfg_t             cfg,
    input  logic [sit_pkg::IL_W-1:0]  il_eff,
    input  logic                      valid_in,
    input  logic [sit_pkg::BLK_W-1:0] seg_quot,
    input  logic [sit_pkg::CNT_W-1:0] seg_rem,
    input  sit_pkg::side2_t           side_in,
    output logic                      valid_out,
    output sit_pkg::rsp_t             rsp
);
    import sit_pkg::*;

    logic                  c_valid_reg;
    logic [BLK_IN_W-1:0]   c_prod_reg;
    logic [BLK_IN_W-1:0]   c_prod_next;
    logic [IL_W-1:0]       c_off_reg;
    logic [BLK_IN_W-1:0]   c_blk_reg;
    logic [IDX_W-1:0]      c_idx_reg;
    logic                  c_multi_reg;
    logic                  c_fail_range_reg;
    logic                  c_fail_cross_reg;
    logic                  c_fail_cross_next;
    logic [BLK_IN_W+IL_W-1:0] prod_full;
    logic [IL_W:0]         off_end;
    logic [IDX_W-1:0]      idx;
    logic [DEV_W-1:0]      devnum;
    logic [BLK_IN_W-1:0]   dblk;

    always_comb
    begin
        prod_full         = seg_quot[BLK_IN_W-1:0] * il_eff;
        c_prod_next       = prod_full[BLK_IN_W-1:0];
        off_end           = {1'b0, side_in.off} + (IL_W+1)'(side_in.s.sz);
        c_fail_cross_next = (off_end > {1'b0, il_eff});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_prod_reg       <= c_prod_next;
            c_off_reg        <= side_in.off;
            c_blk_reg        <= side_in.s.blk[BLK_IN_W-1:0];
            c_idx_reg        <= seg_rem[IDX_W-1:0];
            c_multi_reg      <= side_in.s.multi;
            c_fail_range_reg <= side_in.s.fail_range;
            c_fail_cross_reg <= c_fail_cross_next;
        end
    end

    always_comb
    begin
        idx    = c_multi_reg ? c_idx_reg : '0;
        dblk   = c_multi_reg ? (c_prod_reg + BLK_IN_W'(c_off_reg)) : c_blk_reg;
        devnum = cfg.device[idx];
        rsp    = '0;
        if (c_fail_range_reg)
        begin
            rsp.status = ST_RANGE;
        end
        else if (c_multi_reg && c_fail_cross_reg)
        begin
            rsp.status = ST_CROSS;
        end
        else
        begin
            rsp.status        = (devnum == '0) ? ST_ABSENT : ST_OK;
            rsp.device_index  = idx;
            rsp.device_number = devnum;
            rsp.device_block  = dblk;
        end
    end

    assign valid_out = c_valid_reg;

endmodule

/* sv/swap_interleave_translate.sv */
// top level: config registers, two divider chains, output register with skid
// path from the accepting edge to rsp_valid: two front stages, one 25-cell row
//   dividing by the chunk size, one 25-cell row dividing by the device count,
//   one multiply stage, the output register
// throughput: one word per cycle; the whole row holds while the skid word waits
// reset: all stages empty, config registers at their defaults, no clearing pass
`include "assert_macros.svh"

module swap_interleave_translate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  sit_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output sit_pkg::rsp_t                 rsp_data,
    input  logic                          cfg_write,
    input  logic [sit_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sit_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sit_pkg::*;

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic [IL_W-1:0]  il_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic             multi;
    logic             en;
    logic             accept;

    logic             f_valid;
    logic [BLK_W-1:0] f_blk;
    side1_t           f_side;
    logic             d1_valid;
    logic [BLK_W-1:0] d1_quot;
    logic [IL_W-1:0]  d1_rem;
    logic [$bits(side1_t)-1:0] d1_side;
    side1_t           d1_side_s;
    side2_t           d2_side_in;
    logic             d2_valid;
    logic [BLK_W-1:0] d2_quot;
    logic [CNT_W-1:0] d2_rem;
    logic [$bits(side2_t)-1:0] d2_side;
    logic             bk_valid;
    rsp_t             bk_rsp;

    logic             out_valid_reg;
    logic             out_valid_next;
    rsp_t             out_reg;
    rsp_t             out_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    rsp_t             skid_reg;
    rsp_t             skid_next;
    logic             arrive;

    // config registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SWAP_SIZE: cfg_next.swap_size       = cfg_data[SWAP_W-1:0];
                REG_IL_SIZE:   cfg_next.interleave_size = cfg_data[IL_W-1:0];
                REG_DEV_COUNT: cfg_next.device_count    = cfg_data[CNT_W-1:0];
                REG_MINIROOT:  cfg_next.miniroot_enable = cfg_data[0];
                REG_DEVICE_0:  cfg_next.device[0]       = cfg_data[DEV_W-1:0];
                REG_DEVICE_1:  cfg_next.device[1]       = cfg_data[DEV_W-1:0];
                REG_DEVICE_2:  cfg_next.device[2]       = cfg_data[DEV_W-1:0];
                REG_DEVICE_3:  cfg_next.device[3]       = cfg_data[DEV_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.swap_size       <= SWAP_SIZE_RST;
            cfg_reg.interleave_size <= IL_SIZE_RST;
            cfg_reg.device_count    <= DEV_COUNT_RST;
            cfg_reg.miniroot_enable <= 1'b0;
            cfg_reg.device          <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // zero chunk size reads as one, device count clamped to 1..MAX_DEVICES
    always_comb
    begin
        il_eff = (cfg_reg.interleave_size == '0) ? IL_W'(1) : cfg_reg.interleave_size;
        if (cfg_reg.device_count == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (cfg_reg.device_count > CNT_W'(MAX_DEVICES))
        begin
            cnt_eff = CNT_W'(MAX_DEVICES);
        end
        else
        begin
            cnt_eff = cfg_reg.device_count;
        end
        multi = (cnt_eff > CNT_W'(1));
    end

    assign en        = !skid_valid_reg;
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !req_stall;

    sit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .load      (accept),
        .req       (req_data),
        .cfg       (cfg_reg),
        .multi     (multi),
        .valid_out (f_valid),
        .blk_out   (f_blk),
        .side_out  (f_side)
    );

    // chunk number and offset within the chunk
    sit_div_chain #(
        .NUM_W  (BLK_W),
        .DEN_W  (IL_W),
        .SIDE_W ($bits(side1_t))
    ) u_chunk_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .den       (il_eff),
        .valid_in  (f_valid),
        .num_in    (f_blk),
        .side_in   (f_side),
        .valid_out (d1_valid),
        .quot      (d1_quot),
        .rem       (d1_rem),
        .side_out  (d1_side)
    );

    assign d1_side_s      = side1_t'(d1_side);
    assign d2_side_in.s   = d1_side_s;
    assign d2_side_in.off = d1_rem;

    // device index and chunk number on that device
    sit_div_chain #(
        .NUM_W  (BLK_W),
        .DEN_W  (CNT_W),
        .SIDE_W ($bits(side2_t))
    ) u_dev_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .den       (cnt_eff),
        .valid_in  (d1_valid),
        .num_in    (d1_quot),
        .side_in   (d2_side_in),
        .valid_out (d2_valid),
        .quot      (d2_quot),
        .rem       (d2_rem),
        .side_out  (d2_side)
    );

    sit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .il_eff    (il_eff),
        .valid_in  (d2_valid),
        .seg_quot  (d2_quot),
        .seg_rem   (d2_rem),
        .side_in   (side2_t'(d2_side)),
        .valid_out (bk_valid),
        .rsp       (bk_rsp)
    );

    // output register with one skid word
    always_comb
    begin
        arrive          = en && bk_valid;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || !rsp_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = arrive;
                out_next       = bk_rsp;
            end
        end
        else if (arrive)
        begin
            skid_valid_next = 1'b1;
            skid_next       = bk_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    `ASSERT_CLKRST(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid word without output word")
    `ASSERT_CLKRST(a_range_zero, (rsp_valid && rsp_data.status == ST_RANGE) |-> (rsp_data.device_number == '0 && rsp_data.device_block == '0 && rsp_data.device_index == '0), "range failure with nonzero fields")
    `ASSERT_CLKRST(a_ok_has_device, (rsp_valid && rsp_data.status == ST_OK) |-> (rsp_data.device_number != '0), "ok status with absent device")
    `ASSERT_CLK(a_reset_empty, !rst_n |=> !rsp_valid, "output word valid after reset")

endmodule
